[design/tcaa_pkg.sv]
package tcaa_pkg;

  localparam int unsigned MAX_WAITERS_DEF = 255;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned OCC_W     = 4;
  localparam int unsigned INSIDE_W  = 2;
  localparam int unsigned STREAK_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DW    = 8;

  localparam logic [OCC_W-1:0]    CAPACITY_RST   = 4'd3;
  localparam logic [STREAK_W-1:0] TURN_LIMIT_RST = 8'd5;
  localparam logic [STREAK_W-1:0] STREAK_SAT     = 8'hff;

  // item modes
  localparam logic [MODE_W-1:0] MODE_WAIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENTER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEAVE = 2'd2;

  // inside_state codes
  localparam logic [INSIDE_W-1:0] INSIDE_EMPTY  = 2'd0;
  localparam logic [INSIDE_W-1:0] INSIDE_FIRST  = 2'd1;
  localparam logic [INSIDE_W-1:0] INSIDE_SECOND = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT = 1'd1;

  typedef struct packed {
    logic [OCC_W-1:0]    occupied;
    logic [INSIDE_W-1:0] inside_class;
    logic                streak_set;
    logic                streak_class;
    logic [STREAK_W-1:0] streak_count;
  } arb_state_t;

endpackage

[design/tcaa_if.sv]
interface tcaa_in_if;
  logic                           valid;
  logic                           ready;
  logic [tcaa_pkg::MODE_W-1:0]    mode;
  logic                           user_class;

  modport source (output valid, output mode, output user_class, input ready);
  modport sink   (input valid, input mode, input user_class, output ready);
endinterface

interface tcaa_out_if;
  logic                             valid;
  logic                             ready;
  logic                             granted;
  logic                             error;
  logic [tcaa_pkg::OCC_W-1:0]       occupant_count;
  logic [tcaa_pkg::INSIDE_W-1:0]    inside_state;
  logic                             streak_valid;
  logic                             streak_owner;
  logic [tcaa_pkg::STREAK_W-1:0]    streak_length;

  modport source (output valid, output granted, output error, output occupant_count,
                  output inside_state, output streak_valid, output streak_owner,
                  output streak_length, input ready);
  modport sink   (input valid, input granted, input error, input occupant_count,
                  input inside_state, input streak_valid, input streak_owner,
                  input streak_length, output ready);
endinterface

[design/tcaa_core.sv]
// Next-state logic for one item: admission decision plus counter updates.
module tcaa_core #(
  parameter int unsigned MAX_WAITERS = tcaa_pkg::MAX_WAITERS_DEF,
  localparam int unsigned WAIT_W = $clog2(MAX_WAITERS + 1)
) (
  input  logic [tcaa_pkg::MODE_W-1:0]   mode,
  input  logic                          user_class,
  input  logic [tcaa_pkg::OCC_W-1:0]    capacity,
  input  logic [tcaa_pkg::STREAK_W-1:0] turn_limit,
  input  tcaa_pkg::arb_state_t          st,
  input  logic [WAIT_W-1:0]             wait0,
  input  logic [WAIT_W-1:0]             wait1,
  output tcaa_pkg::arb_state_t          st_nxt,
  output logic [WAIT_W-1:0]             wait0_nxt,
  output logic [WAIT_W-1:0]             wait1_nxt,
  output logic                          granted,
  output logic                          error
);

  localparam logic [WAIT_W-1:0] WAIT_MAX = WAIT_W'(MAX_WAITERS);

  logic [WAIT_W-1:0]             wait_cls;
  logic [WAIT_W-1:0]             wait_turn;
  logic                          turn;
  logic                          admit;
  logic                          clr_streak;
  logic [tcaa_pkg::INSIDE_W-1:0] cls_code;

  assign turn      = (st.streak_count < turn_limit) ? st.streak_class : ~st.streak_class;
  assign wait_cls  = user_class ? wait1 : wait0;
  assign wait_turn = turn ? wait1 : wait0;
  assign cls_code  = user_class ? tcaa_pkg::INSIDE_SECOND : tcaa_pkg::INSIDE_FIRST;

  // entry decision
  always_comb begin
    admit      = 1'b0;
    clr_streak = 1'b0;
    if (st.occupied < capacity) begin
      if (st.occupied == '0) begin
        if (!st.streak_set || user_class == turn) begin
          admit = 1'b1;
        end else if (wait_turn == '0) begin
          // turn holder has nobody waiting: drop the streak, let this one in
          admit      = 1'b1;
          clr_streak = 1'b1;
        end
      end else if (st.inside_class == cls_code) begin
        admit = !st.streak_set || user_class == turn;
      end
    end
  end

  always_comb begin
    st_nxt    = st;
    wait0_nxt = wait0;
    wait1_nxt = wait1;
    granted   = 1'b0;
    error     = 1'b0;
    case (mode)
      tcaa_pkg::MODE_WAIT: begin
        if (wait_cls >= WAIT_MAX) begin
          error = 1'b1;
        end else if (user_class) begin
          wait1_nxt = wait1 + 1'b1;
        end else begin
          wait0_nxt = wait0 + 1'b1;
        end
      end
      tcaa_pkg::MODE_ENTER: begin
        if (wait_cls == '0) begin
          error = 1'b1;
        end else if (admit) begin
          granted         = 1'b1;
          st_nxt.occupied = st.occupied + 1'b1;
          if (st.occupied == '0) begin
            st_nxt.inside_class = cls_code;
          end
          if (user_class) begin
            wait1_nxt = wait1 - 1'b1;
          end else begin
            wait0_nxt = wait0 - 1'b1;
          end
          if (st.streak_set && !clr_streak && st.streak_class == user_class) begin
            if (st.streak_count != tcaa_pkg::STREAK_SAT) begin
              st_nxt.streak_count = st.streak_count + 1'b1;
            end
          end else begin
            st_nxt.streak_set   = 1'b1;
            st_nxt.streak_class = user_class;
            st_nxt.streak_count = tcaa_pkg::STREAK_W'(1);
          end
        end
      end
      tcaa_pkg::MODE_LEAVE: begin
        if (st.occupied == '0) begin
          error = 1'b1;
        end else begin
          st_nxt.occupied = st.occupied - 1'b1;
          if (st.occupied == tcaa_pkg::OCC_W'(1)) begin
            st_nxt.inside_class = tcaa_pkg::INSIDE_EMPTY;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[design/two_class_admission_arbiter.sv]
// Two-class admission arbiter. Each input transfer is one item: register a
// waiter (mode 0), request entry (mode 1) or report a leave (mode 2) for a
// user of class 0 or 1; every item produces exactly one result transfer with
// the grant/error flags and the state after the item. Throughput is one item
// per clock while the output accepts results. An item passes through the
// input register, then the decision logic in tcaa_core feeding the result
// register, where the arbiter state is also updated. While a result waits on
// the output, the input side takes an item only into an empty input register.
// capacity (index 0) and turn_limit (index 1) are written through cfg_*;
// write them only while no item is in flight.
module two_class_admission_arbiter #(
  parameter int unsigned MAX_WAITERS = tcaa_pkg::MAX_WAITERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tcaa_in_if.sink                        in_ch,
  tcaa_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [tcaa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcaa_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int unsigned WAIT_W = $clog2(MAX_WAITERS + 1);

  // configuration
  logic [tcaa_pkg::OCC_W-1:0]    capacity_r;
  logic [tcaa_pkg::STREAK_W-1:0] turn_limit_r;

  // input register
  logic                          s1_valid_r;
  logic [tcaa_pkg::MODE_W-1:0]   s1_mode_r;
  logic                          s1_class_r;

  // arbiter state
  tcaa_pkg::arb_state_t          st_r;
  tcaa_pkg::arb_state_t          st_nxt;
  logic [WAIT_W-1:0]             wait0_r;
  logic [WAIT_W-1:0]             wait1_r;
  logic [WAIT_W-1:0]             wait0_nxt;
  logic [WAIT_W-1:0]             wait1_nxt;

  // result register
  logic                          out_valid_r;
  logic                          granted_r;
  logic                          error_r;
  logic                          granted_nxt;
  logic                          error_nxt;

  logic                          advance;
  logic                          in_xfer;

  // item moves into the result register when that register is free or drains
  assign advance = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_xfer = in_ch.valid && in_ch.ready;

  tcaa_core #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_core (
    .mode         (s1_mode_r),
    .user_class   (s1_class_r),
    .capacity     (capacity_r),
    .turn_limit   (turn_limit_r),
    .st           (st_r),
    .wait0        (wait0_r),
    .wait1        (wait1_r),
    .st_nxt       (st_nxt),
    .wait0_nxt    (wait0_nxt),
    .wait1_nxt    (wait1_nxt),
    .granted      (granted_nxt),
    .error        (error_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= tcaa_pkg::CAPACITY_RST;
      turn_limit_r <= tcaa_pkg::TURN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tcaa_pkg::CFG_CAPACITY:   capacity_r   <= cfg_wdata[tcaa_pkg::OCC_W-1:0];
        tcaa_pkg::CFG_TURN_LIMIT: turn_limit_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r  <= in_ch.mode;
      s1_class_r <= in_ch.user_class;
    end
  end

  // arbiter state commits as the item reaches the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      wait0_r <= '0;
      wait1_r <= '0;
    end else if (advance) begin
      st_r    <= st_nxt;
      wait0_r <= wait0_nxt;
      wait1_r <= wait1_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      granted_r <= granted_nxt;
      error_r   <= error_nxt;
    end
  end

  // state fields of the result are the committed state itself
  assign out_ch.valid          = out_valid_r;
  assign out_ch.granted        = granted_r;
  assign out_ch.error          = error_r;
  assign out_ch.occupant_count = st_r.occupied;
  assign out_ch.inside_state   = st_r.inside_class;
  assign out_ch.streak_valid   = st_r.streak_set;
  assign out_ch.streak_owner   = st_r.streak_class;
  assign out_ch.streak_length  = st_r.streak_count;

endmodule
